@@ rtl/fba_pkg.sv @@
package fba_pkg;

  localparam int AMOUNT_W = 32;
  localparam int SEL_W    = 6;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_READ    = 2'd3
  } fba_cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOFIT     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOTLOADED = 2'd3
  } fba_status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_LOAD,
    OP_SCAN_START,
    OP_SCAN,
    OP_RES_NOFIT,
    OP_RELEASE,
    OP_SWEEP,
    OP_READ_ISSUE,
    OP_READ_DONE,
    OP_RES_NOTLOADED
  } fba_op_t;

  typedef struct packed {
    fba_op_t op;
    logic    load_out;
  } fba_ctrl_t;

  typedef struct packed {
    fba_cmd_t cmd;
    logic     count_zero;
    logic     sel_out;
    logic     hit;
    logic     scan_last;
    logic     sweep_last;
  } fba_stat_t;

endpackage

@@ rtl/fba_if.sv @@
interface fba_item_if import fba_pkg::*; ();
  logic                valid;
  logic                ready;
  fba_cmd_t            command;
  logic [AMOUNT_W-1:0] amount;
  logic [SEL_W-1:0]    block_select;

  modport source (output valid, command, amount, block_select, input ready);
  modport sink (input valid, command, amount, block_select, output ready);
endinterface

interface fba_result_if import fba_pkg::*; ();
  logic                valid;
  logic                ready;
  fba_status_t         status;
  logic [SEL_W-1:0]    block_index;
  logic [AMOUNT_W-1:0] block_size;
  logic [AMOUNT_W-1:0] used_amount;

  modport source (output valid, status, block_index, block_size, used_amount, input ready);
  modport sink (input valid, status, block_index, block_size, used_amount, output ready);
endinterface

interface fba_cfg_if import fba_pkg::*; ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/fba_ctrl.sv @@
module fba_ctrl import fba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  fba_stat_t stat,
  output fba_ctrl_t ctrl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SWEEP,
    S_READ,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    ctrl.op       = OP_NONE;
    ctrl.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.op    = OP_LATCH;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.cmd)
          CMD_LOAD: begin
            ctrl.op    = OP_LOAD;
            state_next = S_RESP;
          end
          CMD_ALLOC: begin
            if (stat.count_zero) begin
              ctrl.op    = OP_RES_NOFIT;
              state_next = S_RESP;
            end else begin
              ctrl.op    = OP_SCAN_START;
              state_next = S_SCAN;
            end
          end
          CMD_RELEASE: begin
            ctrl.op    = OP_RELEASE;
            state_next = stat.count_zero ? S_RESP : S_SWEEP;
          end
          CMD_READ: begin
            if (stat.sel_out) begin
              ctrl.op    = OP_RES_NOTLOADED;
              state_next = S_RESP;
            end else begin
              ctrl.op    = OP_READ_ISSUE;
              state_next = S_READ;
            end
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        ctrl.op = OP_SCAN;
        if (stat.hit || stat.scan_last) begin
          state_next = S_RESP;
        end
      end
      S_SWEEP: begin
        ctrl.op = OP_SWEEP;
        if (stat.sweep_last) begin
          state_next = S_RESP;
        end
      end
      S_READ: begin
        ctrl.op    = OP_READ_DONE;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          ctrl.load_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/fba_datapath.sv @@
module fba_datapath import fba_pkg::*; #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_data,
  input  fba_cmd_t            in_command,
  input  logic [AMOUNT_W-1:0] in_amount,
  input  logic [SEL_W-1:0]    in_block_select,
  input  fba_ctrl_t           ctrl,
  output fba_stat_t           stat,
  output fba_status_t         status,
  output logic [SEL_W-1:0]    block_index,
  output logic [AMOUNT_W-1:0] block_size,
  output logic [AMOUNT_W-1:0] used_amount
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int EW    = CNT_W + 1;
  localparam int SW    = (EW > SEL_W) ? EW : SEL_W + 1;

  typedef struct packed {
    logic                busy;
    logic [AMOUNT_W-1:0] used;
  } meta_t;

  // item latched at accept
  fba_cmd_t            cmd_q;
  logic [AMOUNT_W-1:0] amount_q;
  logic [SEL_W-1:0]    sel_q;

  logic             fit_mode;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] rov;

  logic [AMOUNT_W-1:0] size_mem [MAX_BLOCKS];
  meta_t               meta_mem [MAX_BLOCKS];
  logic [AMOUNT_W-1:0] rd_size;
  meta_t               rd_meta;

  logic [IDX_W-1:0] issue_pos;
  logic [IDX_W-1:0] chk_pos;
  logic [CNT_W-1:0] issue_cnt;
  logic [IDX_W-1:0] swp;

  fba_status_t         res_status;
  logic [SEL_W-1:0]    res_index;
  logic [AMOUNT_W-1:0] res_size;
  logic [AMOUNT_W-1:0] res_used;

  logic [IDX_W-1:0]    raddr;
  logic [IDX_W-1:0]    waddr;
  logic                size_we;
  logic                meta_we;
  meta_t               meta_wdata;
  logic [IDX_W-1:0]    start_pos;
  logic [IDX_W-1:0]    sel_idx;
  logic [IDX_W-1:0]    load_idx;
  logic                full;
  logic                hit;
  logic                scan_last;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p,
                                                input logic [CNT_W-1:0] c);
    logic [EW-1:0] n;
    n = EW'(p) + EW'(1);
    return (n >= EW'(c)) ? '0 : IDX_W'(n);
  endfunction

  assign sel_idx   = IDX_W'(sel_q);
  assign load_idx  = IDX_W'(count);
  assign full      = (EW'(count) >= EW'(MAX_BLOCKS));
  // next fit starts at the roving entry only while it still points into the table
  assign start_pos = (fit_mode && (EW'(rov) < EW'(count))) ? rov : '0;
  assign hit       = !rd_meta.busy && (rd_size >= amount_q);
  assign scan_last = (issue_cnt == count);

  assign stat.cmd        = cmd_q;
  assign stat.count_zero = (count == '0);
  assign stat.sel_out    = (SW'(sel_q) >= SW'(count));
  assign stat.hit        = hit;
  assign stat.scan_last  = scan_last;
  assign stat.sweep_last = ((EW'(swp) + EW'(1)) >= EW'(count));

  always_comb begin
    raddr      = issue_pos;
    waddr      = chk_pos;
    size_we    = 1'b0;
    meta_we    = 1'b0;
    meta_wdata = '0;
    case (ctrl.op)
      OP_LOAD: begin
        waddr   = load_idx;
        size_we = !full;
        meta_we = !full;
      end
      OP_SCAN_START: begin
        raddr = start_pos;
      end
      OP_SCAN: begin
        waddr           = chk_pos;
        meta_we         = hit;
        meta_wdata.busy = 1'b1;
        meta_wdata.used = amount_q;
      end
      OP_SWEEP: begin
        waddr   = swp;
        meta_we = 1'b1;
      end
      OP_READ_ISSUE: begin
        raddr = sel_idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[waddr] <= amount_q;
    end
    if (meta_we) begin
      meta_mem[waddr] <= meta_wdata;
    end
    rd_size <= size_mem[raddr];
    rd_meta <= meta_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= 1'b0;
      count    <= '0;
      rov      <= '0;
    end else begin
      if (cfg_we) begin
        fit_mode <= cfg_data;
      end
      if (ctrl.op == OP_LOAD && !full) begin
        count <= count + CNT_W'(1);
      end
      if (ctrl.op == OP_SCAN && hit) begin
        rov <= wrap_inc(chk_pos, count);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LATCH: begin
        cmd_q    <= in_command;
        amount_q <= in_amount;
        sel_q    <= in_block_select;
      end
      OP_LOAD: begin
        if (full) begin
          res_status <= ST_FULL;
          res_index  <= '0;
          res_size   <= '0;
        end else begin
          res_status <= ST_OK;
          res_index  <= SEL_W'(count);
          res_size   <= amount_q;
        end
        res_used <= '0;
      end
      OP_SCAN_START: begin
        chk_pos   <= start_pos;
        issue_pos <= wrap_inc(start_pos, count);
        issue_cnt <= CNT_W'(1);
      end
      OP_SCAN: begin
        if (hit) begin
          res_status <= ST_OK;
          res_index  <= SEL_W'(chk_pos);
          res_size   <= rd_size;
          res_used   <= amount_q;
        end else if (scan_last) begin
          res_status <= ST_NOFIT;
          res_index  <= '0;
          res_size   <= '0;
          res_used   <= '0;
        end else begin
          chk_pos   <= issue_pos;
          issue_pos <= wrap_inc(issue_pos, count);
          issue_cnt <= issue_cnt + CNT_W'(1);
        end
      end
      OP_RES_NOFIT: begin
        res_status <= ST_NOFIT;
        res_index  <= '0;
        res_size   <= '0;
        res_used   <= '0;
      end
      OP_RELEASE: begin
        res_status <= ST_OK;
        res_index  <= '0;
        res_size   <= '0;
        res_used   <= '0;
        swp        <= '0;
      end
      OP_SWEEP: begin
        swp <= swp + IDX_W'(1);
      end
      OP_READ_DONE: begin
        res_status <= ST_OK;
        res_index  <= sel_q;
        res_size   <= rd_size;
        res_used   <= rd_meta.busy ? rd_meta.used : '0;
      end
      OP_RES_NOTLOADED: begin
        res_status <= ST_NOTLOADED;
        res_index  <= sel_q;
        res_size   <= '0;
        res_used   <= '0;
      end
      default: begin
      end
    endcase
  end

  // output word register, held while the sink stalls
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      status      <= res_status;
      block_index <= res_index;
      block_size  <= res_size;
      used_amount <= res_used;
    end
  end

endmodule

@@ rtl/fit_block_allocator.sv @@
// Table of up to MAX_BLOCKS fixed memory blocks with first-fit or next-fit
// allocation (fit mode written on the cfg channel, bit 0; change it only while
// idle). One request word gives exactly one result word. Requests are taken one
// at a time: a new word is accepted once the previous result has moved into
// the output register, which then waits for the sink without holding up the
// next request. Allocate checks the loaded blocks one table entry per cycle
// through the single read port of the block memories, and release all clears
// one entry per cycle. No clearing pass runs after reset; entries become valid
// as they are loaded.
module fit_block_allocator import fba_pkg::*; #(
  parameter int MAX_BLOCKS = 64
) (
  input logic         clk,
  input logic         rst,
  fba_item_if.sink    req,
  fba_result_if.source rsp,
  fba_cfg_if.sink     cfg
);

  fba_ctrl_t ctrl;
  fba_stat_t stat;

  assign cfg.ready = 1'b1;

  fba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  fba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg.valid),
    .cfg_data        (cfg.data),
    .in_command      (req.command),
    .in_amount       (req.amount),
    .in_block_select (req.block_select),
    .ctrl            (ctrl),
    .stat            (stat),
    .status          (rsp.status),
    .block_index     (rsp.block_index),
    .block_size      (rsp.block_size),
    .used_amount     (rsp.used_amount)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import fba_pkg::*;

  localparam int MAX_BLOCKS  = 64;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_WORDS = 140;
  localparam int RUN_LIMIT   = 500000;
  localparam int REPORT_CAP  = 50;

  typedef struct packed {
    fba_status_t         status;
    logic [SEL_W-1:0]    index;
    logic [AMOUNT_W-1:0] size;
    logic [AMOUNT_W-1:0] used;
  } alloc_result_t;

  typedef struct packed {
    logic                mode;
    fba_cmd_t            cmd;
    logic [AMOUNT_W-1:0] amount;
    logic [SEL_W-1:0]    sel;
    logic                typed;
    alloc_result_t       want;
  } dir_row_t;

  localparam int DIR_ROWS = 23;
  // rows with typed = 1 carry their own result, the rest go through the predictor
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{1'b0, CMD_READ,    32'd0,          6'd0,  1'b1, '{ST_NOTLOADED, 6'd0, 32'd0, 32'd0}},
    '{1'b0, CMD_ALLOC,   32'd5,          6'd0,  1'b1, '{ST_NOFIT, 6'd0, 32'd0, 32'd0}},
    '{1'b0, CMD_RELEASE, 32'd0,          6'd0,  1'b1, '{ST_OK, 6'd0, 32'd0, 32'd0}},
    '{1'b0, CMD_LOAD,    32'd0,          6'd0,  1'b1, '{ST_OK, 6'd0, 32'd0, 32'd0}},
    '{1'b0, CMD_LOAD,    32'hFFFF_FFFF,  6'd0,  1'b1, '{ST_OK, 6'd1, 32'hFFFF_FFFF, 32'd0}},
    '{1'b0, CMD_LOAD,    32'd100,        6'd0,  1'b1, '{ST_OK, 6'd2, 32'd100, 32'd0}},
    '{1'b0, CMD_ALLOC,   32'd0,          6'd0,  1'b1, '{ST_OK, 6'd0, 32'd0, 32'd0}},
    '{1'b0, CMD_ALLOC,   32'hFFFF_FFFF,  6'd0,  1'b1,
      '{ST_OK, 6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    '{1'b0, CMD_ALLOC,   32'd50,         6'd0,  1'b0, '0},
    '{1'b0, CMD_ALLOC,   32'd1,          6'd0,  1'b1, '{ST_NOFIT, 6'd0, 32'd0, 32'd0}},
    '{1'b0, CMD_READ,    32'd0,          6'd1,  1'b0, '0},
    '{1'b0, CMD_READ,    32'd0,          6'd63, 1'b1, '{ST_NOTLOADED, 6'd63, 32'd0, 32'd0}},
    '{1'b0, CMD_RELEASE, 32'hFFFF_FFFF,  6'd63, 1'b1, '{ST_OK, 6'd0, 32'd0, 32'd0}},
    '{1'b0, CMD_READ,    32'd0,          6'd2,  1'b0, '0},
    '{1'b0, CMD_LOAD,    32'd7,          6'd0,  1'b0, '0},
    '{1'b1, CMD_ALLOC,   32'd5,          6'd0,  1'b0, '0},
    '{1'b1, CMD_ALLOC,   32'd5,          6'd0,  1'b0, '0},
    '{1'b1, CMD_ALLOC,   32'd5,          6'd0,  1'b0, '0},
    '{1'b1, CMD_ALLOC,   32'd0,          6'd0,  1'b0, '0},
    '{1'b1, CMD_ALLOC,   32'd1,          6'd0,  1'b0, '0},
    '{1'b1, CMD_READ,    32'd0,          6'd3,  1'b0, '0},
    '{1'b1, CMD_RELEASE, 32'd0,          6'd0,  1'b1, '{ST_OK, 6'd0, 32'd0, 32'd0}},
    '{1'b1, CMD_ALLOC,   32'd200,        6'd0,  1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  fba_item_if   req_if ();
  fba_result_if rsp_if ();
  fba_cfg_if    cfg_if ();

  fit_block_allocator #(.MAX_BLOCKS(MAX_BLOCKS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the block table
  logic [AMOUNT_W-1:0] blk_size [MAX_BLOCKS];
  logic [AMOUNT_W-1:0] blk_used [MAX_BLOCKS];
  logic                blk_busy [MAX_BLOCKS];
  int                  loaded_cnt = 0;
  int                  rove_pos = 0;
  logic                fit_mode_q = 1'b0;

  alloc_result_t pending_results [$];

  int          mismatch_cnt = 0;
  int          words_sent = 0;
  int          results_seen = 0;
  int          alloc_hits = 0;
  int          nofit_cnt = 0;
  int          full_cnt = 0;
  int          mode_writes = 0;
  bit          no_idle = 1'b0;
  int unsigned cycle_cnt = 0;

  function automatic alloc_result_t predict_table_result(fba_cmd_t cmd,
                                                         logic [AMOUNT_W-1:0] amt,
                                                         logic [SEL_W-1:0] sel);
    alloc_result_t r;
    int start;
    int pos;
    int hit;
    int k;
    r = '{ST_OK, '0, '0, '0};
    case (cmd)
      CMD_LOAD: begin
        if (loaded_cnt >= MAX_BLOCKS) begin
          r.status = ST_FULL;
          full_cnt++;
        end else begin
          blk_size[loaded_cnt] = amt;
          blk_used[loaded_cnt] = '0;
          blk_busy[loaded_cnt] = 1'b0;
          r.index = loaded_cnt[SEL_W-1:0];
          r.size = amt;
          loaded_cnt++;
        end
      end
      CMD_ALLOC: begin
        start = (fit_mode_q && rove_pos < loaded_cnt) ? rove_pos : 0;
        hit = -1;
        pos = start;
        for (k = 0; k < loaded_cnt && hit < 0; k++) begin
          if (!blk_busy[pos] && blk_size[pos] >= amt) begin
            hit = pos;
          end else begin
            pos++;
            if (pos >= loaded_cnt) pos = 0;
          end
        end
        if (hit < 0) begin
          r.status = ST_NOFIT;
          nofit_cnt++;
        end else begin
          blk_busy[hit] = 1'b1;
          blk_used[hit] = amt;
          // rover moves past the hit in both modes
          rove_pos = (hit + 1 >= loaded_cnt) ? 0 : hit + 1;
          r.index = hit[SEL_W-1:0];
          r.size = blk_size[hit];
          r.used = amt;
          alloc_hits++;
        end
      end
      CMD_RELEASE: begin
        for (k = 0; k < loaded_cnt; k++) begin
          blk_busy[k] = 1'b0;
          blk_used[k] = '0;
        end
      end
      default: begin
        r.index = sel;
        if (sel >= loaded_cnt) begin
          r.status = ST_NOTLOADED;
        end else begin
          r.size = blk_size[sel];
          r.used = blk_busy[sel] ? blk_used[sel] : '0;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    // quiet after the first screenful, the count still goes up
    if (mismatch_cnt < REPORT_CAP) $display("mismatch at result %0d: %s", results_seen, msg);
    mismatch_cnt++;
  endtask

  task automatic check_result(alloc_result_t got);
    alloc_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result word with nothing pending");
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.index !== want.index)
        report_mismatch($sformatf("block_index got %0d want %0d", got.index, want.index));
      if (got.size !== want.size)
        report_mismatch($sformatf("block_size got %h want %h", got.size, want.size));
      if (got.used !== want.used)
        report_mismatch($sformatf("used_amount got %h want %h", got.used, want.used));
    end
  endtask

  task automatic send_word(fba_cmd_t cmd, logic [AMOUNT_W-1:0] amt, logic [SEL_W-1:0] sel,
                           bit typed, alloc_result_t typed_res);
    int gap;
    alloc_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.amount <= amt;
    req_if.block_select <= sel;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    res = predict_table_result(cmd, amt, sel);
    pending_results.push_back(typed ? typed_res : res);
    words_sent++;
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_fit_mode(logic m);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= m;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    fit_mode_q = m;
    mode_writes++;
    cfg_if.valid <= 1'b0;
  endtask

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= RUN_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // result side: random stalls on ready, check every accepted word
  initial begin : result_sink
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
      check_result('{rsp_if.status, rsp_if.block_index, rsp_if.block_size,
                     rsp_if.used_amount});
      results_seen++;
    end
  end

  initial begin : stimulus
    int r;
    int n;
    int ph;
    int roll;
    int load_pct;
    fba_cmd_t cmd_r;
    logic [AMOUNT_W-1:0] amt_r;
    logic [SEL_W-1:0] sel_r;

    req_if.valid <= 1'b0;
    req_if.command <= CMD_LOAD;
    req_if.amount <= '0;
    req_if.block_select <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_fit_mode(1'b0);
    for (r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].mode != fit_mode_q) write_fit_mode(DIRECTED[r].mode);
      send_word(DIRECTED[r].cmd, DIRECTED[r].amount, DIRECTED[r].sel,
                DIRECTED[r].typed, DIRECTED[r].want);
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      write_fit_mode(ph[0]);
      // heavy loading first so the table grows, then it fills and stays full
      load_pct = (ph == 0) ? 30 : (ph == 1) ? 15 : 10;
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 49) == 0) drain_results();
        roll = $urandom_range(0, 99);
        if (roll < load_pct) cmd_r = CMD_LOAD;
        else if (roll < load_pct + 45) cmd_r = CMD_ALLOC;
        else if (roll < load_pct + 52) cmd_r = CMD_RELEASE;
        else cmd_r = CMD_READ;
        amt_r = $urandom;
        sel_r = SEL_W'($urandom_range(0, 63));
        roll = $urandom_range(0, 9);
        case (cmd_r)
          CMD_LOAD: begin
            if (roll < 7) amt_r = $urandom_range(1, 256);
            else if (roll == 7) amt_r = '0;
            else if (roll == 9) amt_r = 32'hFFFF_FFFF - $urandom_range(0, 3);
          end
          CMD_ALLOC: begin
            // half of the time, sizes right around a loaded block
            if (roll < 5 && loaded_cnt > 0)
              amt_r = blk_size[$urandom_range(0, loaded_cnt - 1)] + $urandom_range(0, 2) - 1;
            else if (roll < 8) amt_r = $urandom_range(0, 300);
            else if (roll == 8) amt_r = '0;
          end
          CMD_READ: begin
            if (roll < 7 && loaded_cnt > 0)
              sel_r = SEL_W'($urandom_range(0, loaded_cnt - 1));
          end
          default: ;
        endcase
        send_word(cmd_r, amt_r, sel_r, 1'b0, '0);
      end
    end

    no_idle = 1'b0;
    drain_results();
    repeat (MAX_BLOCKS + 8) @(posedge clk);

    $display("run: %0d words sent, %0d results checked, %0d fit mode writes",
             words_sent, results_seen, mode_writes);
    $display("allocator: %0d placed, %0d without fit, %0d loads refused on a full table",
             alloc_hits, nofit_cnt, full_cnt);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fba_pkg.sv
rtl/fba_if.sv
rtl/fba_ctrl.sv
rtl/fba_datapath.sv
rtl/fit_block_allocator.sv
sim/tb.sv
